FILE: hw/rtl/gfa_pkg.sv
// Shared types, operation codes and field multiply functions for the Galois field ALU.
package gfa_pkg;

  // Operation codes carried in the mode field of an input transaction.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  // Field selection as held in the configuration register.
  localparam logic FM_GF16  = 1'b0;
  localparam logic FM_GF256 = 1'b1;

  // Reduction polynomials without the leading term.
  localparam logic [7:0] POLY256_LOW = 8'h1d;
  localparam logic [3:0] POLY16_LOW  = 4'h3;

  // One cell handles one exponent bit, so the chain is as long as the exponent.
  localparam int unsigned EXP_BITS = 8;

  // Inverse exponents: the order of the multiplicative group minus one.
  localparam logic [7:0] INV_EXP256 = 8'd254;
  localparam logic [7:0] INV_EXP16  = 8'd14;

  // Multiplicative identity in each field layout (two packed ones in GF(16)).
  localparam logic [7:0] ONE256 = 8'h01;
  localparam logic [7:0] ONE16  = 8'h11;

  // Work item as it moves from cell to cell.
  typedef struct packed {
    logic       valid;
    logic       fm;      // field mode captured when the item entered
    logic [2:0] op;
    logic [7:0] base;    // running square of the element
    logic [7:0] acc;     // running product of the selected squares
    logic [7:0] ex;      // exponent bits not yet consumed, next bit in bit 0
    logic [7:0] mult;    // multiplier applied after the chain
    logic [7:0] xsum;    // operand_a ^ operand_b for add and subtract
    logic       zz;      // both operands zero
  } gfa_item_t;

  // Carry-less multiply reduced by x^8+x^4+x^3+x^2+1.
  function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] sa;
    r  = '0;
    sa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ sa;
      end
      sa = sa[7] ? ({sa[6:0], 1'b0} ^ POLY256_LOW) : {sa[6:0], 1'b0};
    end
    return r;
  endfunction

  // Carry-less multiply reduced by x^4+x+1.
  function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] r;
    logic [3:0] sa;
    r  = '0;
    sa = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        r = r ^ sa;
      end
      sa = sa[3] ? ({sa[2:0], 1'b0} ^ POLY16_LOW) : {sa[2:0], 1'b0};
    end
    return r;
  endfunction

  // Multiply in the selected field; in GF(16) both nibbles are handled independently.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic fm);
    logic [7:0] r;
    if (fm == FM_GF256) begin
      r = gf256_mul(a, b);
    end else begin
      r = {gf16_mul(a[7:4], b[7:4]), gf16_mul(a[3:0], b[3:0])};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/gfa_cell.sv
// One square-and-multiply cell: consumes one exponent bit and hands the item on.
module gfa_cell
  import gfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  gfa_item_t item_in,
  output gfa_item_t item_out
);

  gfa_item_t item_r;
  gfa_item_t item_nxt;

  // Multiply the accumulator by the base when the bit is set, and square the base.
  always_comb begin
    item_nxt      = item_in;
    item_nxt.acc  = item_in.ex[0] ? gf_mul(item_in.acc, item_in.base, item_in.fm)
                                  : item_in.acc;
    item_nxt.base = gf_mul(item_in.base, item_in.base, item_in.fm);
    item_nxt.ex   = {1'b0, item_in.ex[7:1]};
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

FILE: hw/rtl/gfa_final.sv
// Output cell: applies the final multiply, selects the result and holds it for the receiver.
module gfa_final
  import gfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  gfa_item_t  item_in,
  output logic       out_valid,
  output logic [7:0] out_data
);

  logic       valid_r;
  logic [7:0] data_r;
  logic [7:0] prod;
  logic [7:0] data_nxt;

  assign prod = gf_mul(item_in.mult, item_in.acc, item_in.fm);

  // Result selection by operation.
  always_comb begin
    unique case (item_in.op)
      OP_ADD, OP_SUB: data_nxt = item_in.xsum;
      OP_MUL, OP_DIV: data_nxt = prod;
      OP_POW: begin
        if (item_in.zz) begin
          data_nxt = '0;
        end else if (item_in.fm == FM_GF256) begin
          data_nxt = prod;
        end else begin
          data_nxt = {4'h0, prod[3:0]};
        end
      end
      default: data_nxt = '0;
    endcase
  end

  // Output register; it moves whenever the chain advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= item_in.valid;
      data_r  <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hw/rtl/galois_field_alu.sv
// Top level of the Galois field ALU: input decode, cell chain, output stage and checks.
//
// The block computes one GF(256) or packed dual GF(16) operation per input transaction.
// Input channel in_*: tdata carries mode, operand_a and operand_b; each accepted
// transaction yields exactly one output transaction on out_*, in order.
// Configuration channel cfg_*: a one-bit field_mode write, always accepted; it
// should be written only while the block is empty. Each item carries the mode
// that was in force when it was accepted.
// Every operation is mapped onto a chain of eight identical square-and-multiply
// cells (one per exponent bit) followed by an output cell that applies a final
// multiply: multiply is b^1 * a, divide is b^254 (b^14 per nibble) * a, and power
// is a^b * 1 (low nibble of a only in GF(16)). Add and subtract ride along the chain as a^b.
// An accepted transaction passes through the cell registers and then the output register;
// throughput is one transaction per cycle while the receiver does not stall the chain.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_tready falls, so nothing is lost; bubbles in the chain are not squeezed out.
// Reset (rst_n low, synchronous) empties the chain and sets field_mode to GF(256).
module galois_field_alu
  import gfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,      // [0] field_mode
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [2:0] mode, [10:3] operand_a, [18:11] operand_b
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata      // [7:0] result
);

  logic       field_mode_r;
  logic       adv;
  logic [2:0] op;
  logic [7:0] opa;
  logic [7:0] opb;
  gfa_item_t  chain [EXP_BITS+1];

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_mode_r <= FM_GF256;
    end else if (cfg_valid && cfg_ready) begin
      field_mode_r <= cfg_data[0];
    end
  end

  // The chain moves whenever the output register is free or being drained.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign op  = in_tdata[2:0];
  assign opa = in_tdata[10:3];
  assign opb = in_tdata[18:11];

  // Map the operation onto base, exponent and final multiplier.
  always_comb begin
    chain[0].valid = in_tvalid;
    chain[0].fm    = field_mode_r;
    chain[0].op    = op;
    chain[0].acc   = (field_mode_r == FM_GF256) ? ONE256 : ONE16;
    chain[0].xsum  = opa ^ opb;
    chain[0].zz    = (opa == 8'h00) && (opb == 8'h00);
    chain[0].base  = opb;
    chain[0].mult  = opa;
    unique case (op)
      OP_MUL: begin
        chain[0].ex = 8'd1;
      end
      OP_DIV: begin
        chain[0].ex = (field_mode_r == FM_GF256) ? INV_EXP256 : INV_EXP16;
      end
      OP_POW: begin
        chain[0].base = (field_mode_r == FM_GF256) ? opa : {4'h0, opa[3:0]};
        chain[0].ex   = opb;
        chain[0].mult = (field_mode_r == FM_GF256) ? ONE256 : ONE16;
      end
      default: begin
        chain[0].ex = '0;
      end
    endcase
  end

  // Square-and-multiply cells, one per exponent bit.
  for (genvar k = 0; k < EXP_BITS; k++) begin : g_cell
    gfa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .item_in  (chain[k]),
      .item_out (chain[k+1])
    );
  end

  // Final multiply and output register.
  gfa_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item_in   (chain[EXP_BITS]),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

  // An accepted transaction occupies the first cell on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> chain[1].valid)
    else $error("accepted transaction did not enter the cell chain");

  // A new result appears only when the last cell held an item.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(chain[EXP_BITS].valid))
    else $error("result appeared without an item in the last cell");

  // A stalled chain keeps its contents in the last cell.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(chain[EXP_BITS]))
    else $error("last cell changed while the chain was stalled");

endmodule
